// ----- rtl/rspc_pkg.sv -----
// shared types and constants of the rotary stepper position controller
`default_nettype none

package rspc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_MOVE = 3'd1,
    MODE_HOME = 3'd2,
    MODE_LED  = 3'd3,
    MODE_TURN = 3'd4
  } mode_t;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_MOVE = 3'd1;
  localparam logic [2:0] OP_HOME = 3'd2;
  localparam logic [2:0] OP_LED  = 3'd3;
  localparam logic [2:0] OP_TURN = 3'd4;

  localparam int SPT_W   = 13;
  localparam int LED_W   = 12;
  localparam int OVS_W   = 8;
  localparam int LIMIT_W = 13;
  localparam int HP_W    = 16;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_TURN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_PITCH_STEPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_OVERSHOOT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_SEARCH_LIMIT = 2'd3;

  localparam logic [SPT_W-1:0]   SPT_RESET   = 13'd1600;
  localparam logic [LED_W-1:0]   LED_RESET   = 12'd34;
  localparam logic [OVS_W-1:0]   OVS_RESET   = 8'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd1610;

endpackage

`default_nettype wire

// ----- rtl/rspc_move_plan.sv -----
// shortest-way move planning and wrapped led advance target
`default_nettype none

module rspc_move_plan #(
  parameter int POS_BITS = 12,
  parameter int SL_W     = 13
) (
  input  wire logic [POS_BITS-1:0]            cur_pos,
  input  wire logic [POS_BITS-1:0]            target,
  input  wire logic [rspc_pkg::SPT_W-1:0]     steps_per_turn,
  input  wire logic [rspc_pkg::LED_W-1:0]     led_pitch_steps,
  output logic                                move_dir_cw,
  output logic [SL_W-1:0]                     move_steps,
  output logic [POS_BITS-1:0]                 led_target
);

  localparam int W = (POS_BITS > rspc_pkg::SPT_W) ? POS_BITS : rspc_pkg::SPT_W;

  logic [W-1:0] cp_w;
  logic [W-1:0] tg_w;
  logic [W-1:0] spt_w;
  logic [W-1:0] half_w;
  logic [W-1:0] dist_w;
  logic [W-1:0] steps_w;
  logic [W:0]   sum_w;
  logic [W:0]   wrap_w;
  logic         below;
  logic         shorter;

  assign cp_w   = W'(cur_pos);
  assign tg_w   = W'(target);
  assign spt_w  = W'(steps_per_turn);
  assign half_w = spt_w >> 1;
  assign below  = cp_w < tg_w;
  assign dist_w = below ? (tg_w - cp_w) : (cp_w - tg_w);
  assign shorter = dist_w < half_w;

  always_comb begin
    if (shorter) begin
      steps_w = dist_w;
    end else if (spt_w > dist_w) begin
      steps_w = spt_w - dist_w;
    end else begin
      steps_w = '0;
    end
  end

  assign move_dir_cw = below ? shorter : !shorter;
  assign move_steps  = SL_W'(steps_w);

  // led advance wraps once around the circle
  assign sum_w  = (W+1)'(cur_pos) + (W+1)'(led_pitch_steps);
  assign wrap_w = (sum_w >= (W+1)'(steps_per_turn)) ? (sum_w - (W+1)'(steps_per_turn)) : sum_w;
  assign led_target = wrap_w[POS_BITS-1:0];

endmodule

`default_nettype wire

// ----- rtl/rotary_stepper_position_controller.sv -----
// top level: step/direction controller with moves, homing, led advance and full turns
`default_nettype none

// One input word is one timing tick and yields exactly one output word showing the
// state after that tick. Each tick passes through combinational logic between the
// controller state registers and the output register, so a word is accepted every
// clock; in_stall rises only while the output register holds a word that the sink
// stalls. Commands (op) are taken only while idle; each step is high for
// half_period ticks and low for half_period ticks, counted in ticks, not clocks.
// Configuration writes are expected only while no command runs.
module rotary_stepper_position_controller #(
  parameter int POS_BITS   = 12,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              cfg_we,
  input  wire logic [rspc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rspc_pkg::CFG_W-1:0]        cfg_data,

  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [2:0]                        in_op,
  input  wire logic [POS_BITS-1:0]               in_target_position,
  input  wire logic [rspc_pkg::HP_W-1:0]         in_half_period,
  input  wire logic                              in_turn_clockwise,
  input  wire logic                              in_home_switch,

  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_step_level,
  output logic                                   out_dir_clockwise,
  output logic                                   out_driver_enabled,
  output logic                                   out_busy_res,
  output logic [POS_BITS-1:0]                    out_position,
  output logic                                   out_done_res,
  output logic                                   out_home_failed
);

  localparam int SL_W = (POS_BITS + 1 > rspc_pkg::SPT_W) ? POS_BITS + 1 : rspc_pkg::SPT_W;

  // configuration
  logic [rspc_pkg::SPT_W-1:0]   spt_r;
  logic [rspc_pkg::LED_W-1:0]   led_r;
  logic [rspc_pkg::OVS_W-1:0]   ovs_r;
  logic [rspc_pkg::LIMIT_W-1:0] limit_r;

  // controller state
  rspc_pkg::mode_t              mode_r, mode_nxt;
  logic [POS_BITS-1:0]          pos_r, pos_nxt;
  logic [SL_W-1:0]              steps_r, steps_nxt;
  logic [TIMER_BITS-1:0]        timer_r, timer_nxt;
  logic                         step_high_r, step_high_nxt;
  logic                         dir_r, dir_nxt;
  logic [TIMER_BITS-1:0]        lhp_r, lhp_nxt;
  logic [POS_BITS-1:0]          ltgt_r, ltgt_nxt;
  logic                         fail_r, fail_nxt;
  logic                         done_nxt;

  logic                         out_valid_r;
  logic                         take;

  logic [TIMER_BITS-1:0]        hp_tb;
  logic [TIMER_BITS-1:0]        hp_new;
  logic [SL_W-1:0]              budget;
  logic [SL_W-1:0]              steps_dec;
  logic                         plan_dir;
  logic [SL_W-1:0]              plan_steps;
  logic [POS_BITS-1:0]          led_target;

  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= rspc_pkg::SPT_RESET;
      led_r   <= rspc_pkg::LED_RESET;
      ovs_r   <= rspc_pkg::OVS_RESET;
      limit_r <= rspc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rspc_pkg::CFG_STEPS_PER_TURN:    spt_r   <= cfg_data[rspc_pkg::SPT_W-1:0];
        rspc_pkg::CFG_LED_PITCH_STEPS:   led_r   <= cfg_data[rspc_pkg::LED_W-1:0];
        rspc_pkg::CFG_HOME_OVERSHOOT:    ovs_r   <= cfg_data[rspc_pkg::OVS_W-1:0];
        rspc_pkg::CFG_HOME_SEARCH_LIMIT: limit_r <= cfg_data[rspc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  rspc_move_plan #(
    .POS_BITS (POS_BITS),
    .SL_W     (SL_W)
  ) u_plan (
    .cur_pos         (pos_r),
    .target          (in_target_position),
    .steps_per_turn  (spt_r),
    .led_pitch_steps (led_r),
    .move_dir_cw     (plan_dir),
    .move_steps      (plan_steps),
    .led_target      (led_target)
  );

  assign hp_tb  = TIMER_BITS'(in_half_period);
  assign hp_new = (hp_tb == '0) ? TIMER_BITS'(1) : hp_tb;
  assign budget = (pos_r != '0) ? (SL_W'(pos_r) + SL_W'(ovs_r)) : SL_W'(limit_r);
  assign steps_dec = (steps_r != '0) ? (steps_r - SL_W'(1)) : steps_r;

  always_comb begin
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    steps_nxt     = steps_r;
    timer_nxt     = timer_r;
    step_high_nxt = step_high_r;
    dir_nxt       = dir_r;
    lhp_nxt       = lhp_r;
    ltgt_nxt      = ltgt_r;
    fail_nxt      = fail_r;
    done_nxt      = 1'b0;
    if (mode_r == rspc_pkg::MODE_IDLE) begin
      unique case (in_op)
        rspc_pkg::OP_MOVE: begin
          lhp_nxt  = hp_new;
          ltgt_nxt = in_target_position;
          dir_nxt  = plan_dir;
          if (plan_steps == '0) begin
            pos_nxt  = in_target_position;
            done_nxt = 1'b1;
          end else begin
            mode_nxt      = rspc_pkg::MODE_MOVE;
            steps_nxt     = plan_steps;
            step_high_nxt = 1'b1;
            timer_nxt     = hp_new - TIMER_BITS'(1);
          end
        end
        rspc_pkg::OP_HOME: begin
          lhp_nxt  = hp_new;
          fail_nxt = 1'b0;
          dir_nxt  = 1'b0;
          if (in_home_switch) begin
            pos_nxt  = '0;
            done_nxt = 1'b1;
          end else if (budget == '0) begin
            fail_nxt = 1'b1;
            done_nxt = 1'b1;
          end else begin
            mode_nxt      = rspc_pkg::MODE_HOME;
            steps_nxt     = budget;
            step_high_nxt = 1'b1;
            timer_nxt     = hp_new - TIMER_BITS'(1);
          end
        end
        rspc_pkg::OP_LED: begin
          lhp_nxt  = hp_new;
          ltgt_nxt = led_target;
          dir_nxt  = 1'b1;
          if (led_r == '0) begin
            pos_nxt  = led_target;
            done_nxt = 1'b1;
          end else begin
            mode_nxt      = rspc_pkg::MODE_LED;
            steps_nxt     = SL_W'(led_r);
            step_high_nxt = 1'b1;
            timer_nxt     = hp_new - TIMER_BITS'(1);
          end
        end
        rspc_pkg::OP_TURN: begin
          lhp_nxt = hp_new;
          dir_nxt = in_turn_clockwise;
          if (spt_r == '0) begin
            done_nxt = 1'b1;
          end else begin
            mode_nxt      = rspc_pkg::MODE_TURN;
            steps_nxt     = SL_W'(spt_r);
            step_high_nxt = 1'b1;
            timer_nxt     = hp_new - TIMER_BITS'(1);
          end
        end
        default: ;
      endcase
    end else if (timer_r != '0) begin
      timer_nxt = timer_r - TIMER_BITS'(1);
    end else if (step_high_r) begin
      step_high_nxt = 1'b0;
      timer_nxt     = lhp_r - TIMER_BITS'(1);
    end else if ((mode_r == rspc_pkg::MODE_HOME && in_home_switch) || steps_dec == '0) begin
      // step finished and command completes
      if (mode_r == rspc_pkg::MODE_HOME) begin
        if (in_home_switch) begin
          pos_nxt = '0;
        end else begin
          fail_nxt = 1'b1;
        end
      end else if (mode_r == rspc_pkg::MODE_MOVE || mode_r == rspc_pkg::MODE_LED) begin
        pos_nxt = ltgt_r;
      end
      mode_nxt      = rspc_pkg::MODE_IDLE;
      step_high_nxt = 1'b0;
      steps_nxt     = '0;
      timer_nxt     = '0;
      done_nxt      = 1'b1;
    end else begin
      steps_nxt     = steps_dec;
      step_high_nxt = 1'b1;
      timer_nxt     = lhp_r - TIMER_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= rspc_pkg::MODE_IDLE;
      pos_r       <= '0;
      steps_r     <= '0;
      timer_r     <= '0;
      step_high_r <= 1'b0;
      dir_r       <= 1'b0;
      lhp_r       <= '0;
      ltgt_r      <= '0;
      fail_r      <= 1'b0;
    end else if (take) begin
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      steps_r     <= steps_nxt;
      timer_r     <= timer_nxt;
      step_high_r <= step_high_nxt;
      dir_r       <= dir_nxt;
      lhp_r       <= lhp_nxt;
      ltgt_r      <= ltgt_nxt;
      fail_r      <= fail_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_step_level     <= step_high_nxt;
      out_dir_clockwise  <= dir_nxt;
      out_driver_enabled <= (mode_nxt != rspc_pkg::MODE_IDLE);
      out_busy_res       <= (mode_nxt != rspc_pkg::MODE_IDLE);
      out_position       <= pos_nxt;
      out_done_res       <= done_nxt;
      out_home_failed    <= fail_nxt;
    end
  end

endmodule

`default_nettype wire
